FILE: rtl/assert_macros.svh
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ssc_pkg.sv
package ssc_pkg;

  typedef enum logic [1:0] {
    EV_TICK    = 2'd0,
    EV_CHANGED = 2'd1,
    EV_INVALID = 2'd2
  } event_e;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_ZERO = 8'd48;

  // "HH:MM:SS" occupies the first eight bytes of the line
  localparam int unsigned PARSE_LEN = 8;
  localparam int unsigned POS_HOUR  = 0;
  localparam int unsigned POS_MIN   = 3;
  localparam int unsigned POS_SEC   = 6;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [7:0] HOUR_LIM = 8'd24;
  localparam logic [7:0] MS_LIM   = 8'd59;

endpackage

FILE: rtl/ssc_in_if.sv
interface ssc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

FILE: rtl/ssc_out_if.sv
interface ssc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;

  modport source (output valid, output event_res, output hours, output minutes,
                  output seconds, input ready);
  modport sink   (input valid, input event_res, input hours, input minutes,
                  input seconds, output ready);
endinterface

FILE: rtl/serial_settable_time_of_day_clock.sv
// Channel  Dir  Fields                               Beat
// in_i     in   kind, rx_byte                        valid & ready
// out_o    out  event_res, hours, minutes, seconds   valid & ready
//
// One item per cycle; a tick or a carriage return shows its result in the cycle
// after acceptance, other bytes give no result.
// The single result register sets the rate: in_i.ready is low only while a
// result waits and out_o.ready is low.
// Reset clears the time to 00:00:00, the line buffer to zero and the result
// register to empty.
module serial_settable_time_of_day_clock import ssc_pkg::*; #(
  parameter int unsigned LINE_LENGTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssc_in_if.sink    in_i,
  ssc_out_if.source out_o
);

  localparam int unsigned PosW = $clog2(LINE_LENGTH + 1);

  logic [7:0]      line_q [LINE_LENGTH];
  logic [7:0]      line_d [LINE_LENGTH];
  logic [PosW-1:0] pos_q, pos_d;
  logic [4:0]      hh_q, hh_d;
  logic [5:0]      mm_q, mm_d;
  logic [5:0]      ss_q, ss_d;

  logic            out_valid_q, out_valid_d;
  event_e          ev_q, ev_d;
  logic [4:0]      oh_q;
  logic [5:0]      om_q, os_q;

  logic            accept;
  logic            pos_full;
  logic [7:0]      eff [PARSE_LEN];
  logic [7:0]      f_h, f_m, f_s;
  logic            time_ok;
  logic            has_res;

  function automatic logic [7:0] two_digits(input logic [7:0] a, input logic [7:0] b);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [11:0] sum;
    hi  = a - CHAR_ZERO;
    lo  = b - CHAR_ZERO;
    sum = {4'd0, hi} * 12'd10 + {4'd0, lo};
    return sum[7:0];
  endfunction

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pos_full   = (pos_q == PosW'(LINE_LENGTH));

  // the parse sees the incoming byte at the current position, as if it were already in the buffer
  always_comb begin
    for (int i = 0; i < PARSE_LEN; i++) begin
      eff[i] = (!pos_full && pos_q == PosW'(i)) ? in_i.rx_byte : line_q[i];
    end
  end

  assign f_h     = two_digits(eff[POS_HOUR], eff[POS_HOUR+1]);
  assign f_m     = two_digits(eff[POS_MIN],  eff[POS_MIN+1]);
  assign f_s     = two_digits(eff[POS_SEC],  eff[POS_SEC+1]);
  assign time_ok = (f_h < HOUR_LIM) && (f_m <= MS_LIM) && (f_s <= MS_LIM);

  always_comb begin
    line_d  = line_q;
    pos_d   = pos_q;
    hh_d    = hh_q;
    mm_d    = mm_q;
    ss_d    = ss_q;
    ev_d    = ev_q;
    has_res = 1'b0;
    if (accept) begin
      if (in_i.kind == KIND_TICK) begin
        has_res = 1'b1;
        ev_d    = EV_TICK;
        if (ss_q == SEC_MAX) begin
          ss_d = '0;
          if (mm_q == MIN_MAX) begin
            mm_d = '0;
            hh_d = (hh_q == HOUR_MAX) ? 5'd0 : hh_q + 5'd1;
          end else begin
            mm_d = mm_q + 6'd1;
          end
        end else begin
          ss_d = ss_q + 6'd1;
        end
      end else if (in_i.rx_byte != CHAR_CR) begin
        if (!pos_full) begin
          for (int i = 0; i < LINE_LENGTH; i++) begin
            if (pos_q == PosW'(i)) begin
              line_d[i] = in_i.rx_byte;
            end
          end
          pos_d = pos_q + PosW'(1);
        end
      end else begin
        has_res = 1'b1;
        if (time_ok) begin
          hh_d = f_h[4:0];
          mm_d = f_m[5:0];
          ss_d = f_s[5:0];
          ev_d = EV_CHANGED;
        end else begin
          ev_d = EV_INVALID;
        end
        pos_d = '0;
        for (int i = 0; i < LINE_LENGTH; i++) begin
          line_d[i] = '0;
        end
      end
    end
    if (accept) begin
      out_valid_d = has_res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINE_LENGTH; i++) begin
        line_q[i] <= '0;
      end
      pos_q       <= '0;
      hh_q        <= '0;
      mm_q        <= '0;
      ss_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      pos_q       <= pos_d;
      hh_q        <= hh_d;
      mm_q        <= mm_d;
      ss_q        <= ss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_res) begin
      ev_q <= ev_d;
      oh_q <= hh_d;
      om_q <= mm_d;
      os_q <= ss_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = ev_q;
  assign out_o.hours     = oh_q;
  assign out_o.minutes   = om_q;
  assign out_o.seconds   = os_q;

endmodule

FILE: rtl/ssc_checker.sv
`include "assert_macros.svh"

module ssc_checker import ssc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_kind_i,
  input logic [7:0] in_rx_byte_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_event_res_i,
  input logic [4:0] out_hours_i,
  input logic [5:0] out_minutes_i,
  input logic [5:0] out_seconds_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_event_res_i) && $stable(out_hours_i) && $stable(out_minutes_i) && $stable(out_seconds_i), "stalled result changed")
  `ASSERT_RST(a_out_range, clk_i, rst_ni, out_valid_i |-> out_hours_i <= HOUR_MAX && out_minutes_i <= MIN_MAX && out_seconds_i <= SEC_MAX && out_event_res_i != 2'd3, "result out of range")
  `ASSERT_RST(a_only_full_stalls, clk_i, rst_ni, !in_ready_i |-> out_valid_i && !out_ready_i, "input stalled without a waiting result")
  `ASSERT_RST(a_tick_result, clk_i, rst_ni, in_beat && in_kind_i == KIND_TICK |=> out_valid_i && out_event_res_i == EV_TICK, "tick gave no tick result")
  `ASSERT_RST(a_byte_silent, clk_i, rst_ni, in_beat && in_kind_i == KIND_BYTE && in_rx_byte_i != CHAR_CR |=> !out_valid_i, "plain byte produced a result")

endmodule

bind serial_settable_time_of_day_clock ssc_checker u_ssc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_kind_i       (in_i.kind),
  .in_rx_byte_i    (in_i.rx_byte),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_event_res_i (out_o.event_res),
  .out_hours_i     (out_o.hours),
  .out_minutes_i   (out_o.minutes),
  .out_seconds_i   (out_o.seconds)
);
